// ===== sv/jsu_pkg.sv =====
// jsu_pkg: shared types and constants of the json string unescaper
// no dependencies; imported by every module of the block
`default_nettype none

package jsu_pkg;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [15:0] HIGH_MIN = 16'hD800;
    localparam logic [15:0] HIGH_MAX = 16'hDBFF;
    localparam logic [15:0] LOW_MIN  = 16'hDC00;
    localparam logic [15:0] LOW_MAX  = 16'hDFFF;

    localparam int unsigned CP_W      = 21;
    localparam int unsigned JOB_DEPTH = 4;
    localparam int unsigned JOB_PTR_W = $clog2(JOB_DEPTH);
    localparam int unsigned JOB_CNT_W = $clog2(JOB_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_QUOTE   = 2'd1,
        KIND_NUL     = 2'd2,
        KIND_NOQUOTE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_STR,
        PH_ESC,
        PH_HEX1,
        PH_HS_BS,
        PH_HS_U,
        PH_HEX2
    } t_phase;

    // one queued job: a raw byte, a code point to encode, or an end marker
    typedef struct packed {
        logic             utf;
        t_kind            kind;
        logic [CP_W-1:0]  value;
    } t_job;

endpackage

`default_nettype wire

// ===== sv/jsu_if.sv =====
// jsu_in_if / jsu_out_if: valid/ready channels of the unescaper
// no dependencies
`default_nettype none

interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] kind;
    logic       last;

    modport source (output valid, output out_byte, output kind, output last, input ready);
    modport sink   (input valid, input out_byte, input kind, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/jsu_front.sv =====
// jsu_front: accepts input words, tracks escape and hex phases, queues jobs
// depends on jsu_pkg and jsu_in_if
`default_nettype none

module jsu_front (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    jsu_in_if.sink           i_in,
    input  wire logic        i_q_full,
    output logic             o_push,
    output jsu_pkg::t_job    o_job
);
    import jsu_pkg::*;

    t_phase       r_phase, n_phase;
    logic [15:0]  r_first_unit, n_first_unit;
    logic [15:0]  r_hex_value, n_hex_value;
    logic [2:0]   r_digit_count, n_digit_count;
    logic         r_hex_run_ended, n_hex_run_ended;

    logic         w_acc;
    logic [7:0]   w_b;
    logic [4:0]   w_digit;
    logic [15:0]  w_hex_next;
    logic         w_run_next;
    logic [2:0]   w_cnt_next;
    logic         w_hex_done;
    logic         w_is_low;
    logic         w_is_high;
    logic [7:0]   w_esc_val;
    logic         w_has_job;
    t_job         w_job;

    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] d;
        d = 5'd16;
        if (b inside {[8'h30:8'h39]}) begin
            d = {1'b0, b[3:0]};
        end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            d = {1'b0, b[3:0] + 4'd9};
        end
        return d;
    endfunction

    function automatic logic [7:0] esc_map(input logic [7:0] b);
        logic [7:0] v;
        case (b)
            8'h62:   v = 8'h08;
            8'h66:   v = 8'h0C;
            8'h6E:   v = 8'h0A;
            8'h72:   v = 8'h0D;
            8'h74:   v = 8'h09;
            default: v = b;
        endcase
        return v;
    endfunction

    function automatic t_job raw_job(input logic [7:0] b);
        t_job j;
        j.utf   = 1'b0;
        j.kind  = KIND_DATA;
        j.value = {{(CP_W-8){1'b0}}, b};
        return j;
    endfunction

    function automatic t_job end_job(input t_kind k);
        t_job j;
        j.utf   = 1'b0;
        j.kind  = k;
        j.value = '0;
        return j;
    endfunction

    assign w_b        = i_in.in_byte;
    assign i_in.ready = !i_q_full;
    assign w_acc      = i_in.valid && !i_q_full;

    assign w_digit    = hex_digit(w_b);
    assign w_hex_next = (!r_hex_run_ended && !w_digit[4]) ?
                        {r_hex_value[11:0], w_digit[3:0]} : r_hex_value;
    assign w_run_next = r_hex_run_ended | w_digit[4];
    assign w_cnt_next = r_digit_count + 3'd1;
    assign w_hex_done = (w_cnt_next >= 3'd4);
    assign w_is_low   = (w_hex_next >= LOW_MIN) && (w_hex_next <= LOW_MAX);
    assign w_is_high  = (w_hex_next >= HIGH_MIN) && (w_hex_next <= HIGH_MAX);
    assign w_esc_val  = esc_map(w_b);

    // next state
    always_comb begin
        n_phase         = r_phase;
        n_first_unit    = r_first_unit;
        n_hex_value     = r_hex_value;
        n_digit_count   = r_digit_count;
        n_hex_run_ended = r_hex_run_ended;
        if (w_acc) begin
            case (r_phase)
                PH_IDLE: begin
                    if (w_b == CH_QUOTE) n_phase = PH_STR;
                end
                PH_STR, PH_HS_BS: begin
                    if (w_b == CH_NUL || w_b == CH_QUOTE) begin
                        n_phase = PH_IDLE;
                    end else if (w_b == CH_BSLASH) begin
                        n_phase = (r_phase == PH_HS_BS) ? PH_HS_U : PH_ESC;
                    end else begin
                        n_phase = PH_STR;
                    end
                end
                PH_ESC, PH_HS_U: begin
                    if (w_b == CH_NUL) begin
                        n_phase = PH_IDLE;
                    end else if (w_b == CH_U) begin
                        n_phase         = (r_phase == PH_HS_U) ? PH_HEX2 : PH_HEX1;
                        n_hex_value     = '0;
                        n_digit_count   = '0;
                        n_hex_run_ended = 1'b0;
                    end else begin
                        n_phase = PH_STR;
                    end
                end
                PH_HEX1, PH_HEX2: begin
                    if (w_b == CH_NUL) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_hex_value     = w_hex_next;
                        n_hex_run_ended = w_run_next;
                        n_digit_count   = w_cnt_next;
                        if (w_hex_done) begin
                            n_phase = PH_STR;
                            if (r_phase == PH_HEX1 && w_is_high) begin
                                n_first_unit = w_hex_next;
                                n_phase      = PH_HS_BS;
                            end
                        end
                    end
                end
                default: n_phase = PH_IDLE;
            endcase
        end
    end

    // job output
    always_comb begin
        w_has_job = 1'b0;
        w_job     = end_job(KIND_DATA);
        case (r_phase)
            PH_IDLE: begin
                if (w_b != CH_QUOTE) begin
                    w_has_job = 1'b1;
                    w_job     = end_job(KIND_NOQUOTE);
                end
            end
            PH_STR, PH_HS_BS: begin
                if (w_b == CH_NUL) begin
                    w_has_job = 1'b1;
                    w_job     = end_job(KIND_NUL);
                end else if (w_b == CH_QUOTE) begin
                    w_has_job = 1'b1;
                    w_job     = end_job(KIND_QUOTE);
                end else if (w_b != CH_BSLASH) begin
                    w_has_job = 1'b1;
                    w_job     = raw_job(w_b);
                end
            end
            PH_ESC, PH_HS_U: begin
                if (w_b == CH_NUL) begin
                    w_has_job = 1'b1;
                    w_job     = end_job(KIND_NUL);
                end else if (w_b != CH_U) begin
                    w_has_job = 1'b1;
                    w_job     = raw_job(w_esc_val);
                end
            end
            PH_HEX1: begin
                if (w_b == CH_NUL) begin
                    w_has_job = 1'b1;
                    w_job     = end_job(KIND_NUL);
                end else if (w_hex_done && w_hex_next != 16'd0 && !w_is_low && !w_is_high) begin
                    w_has_job   = 1'b1;
                    w_job.utf   = 1'b1;
                    w_job.value = {{(CP_W-16){1'b0}}, w_hex_next};
                end
            end
            PH_HEX2: begin
                if (w_b == CH_NUL) begin
                    w_has_job = 1'b1;
                    w_job     = end_job(KIND_NUL);
                end else if (w_hex_done && w_is_low) begin
                    w_has_job   = 1'b1;
                    w_job.utf   = 1'b1;
                    w_job.value = {1'b0, r_first_unit[9:0], w_hex_next[9:0]} | 21'h10000;
                end
            end
            default: w_has_job = 1'b0;
        endcase
    end

    assign o_push = w_acc && w_has_job;
    assign o_job  = w_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= PH_IDLE;
            r_first_unit    <= '0;
            r_hex_value     <= '0;
            r_digit_count   <= '0;
            r_hex_run_ended <= 1'b0;
        end else begin
            r_phase         <= n_phase;
            r_first_unit    <= n_first_unit;
            r_hex_value     <= n_hex_value;
            r_digit_count   <= n_digit_count;
            r_hex_run_ended <= n_hex_run_ended;
        end
    end

endmodule

`default_nettype wire

// ===== sv/jsu_fifo.sv =====
// jsu_fifo: short job queue between front and back
// depends on jsu_pkg
`default_nettype none

module jsu_fifo (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire jsu_pkg::t_job   i_push_job,
    output logic                 o_full,
    output logic                 o_valid,
    output jsu_pkg::t_job        o_job,
    input  wire logic            i_pop
);
    import jsu_pkg::*;

    t_job                  r_mem [JOB_DEPTH];
    logic [JOB_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [JOB_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [JOB_CNT_W-1:0]  r_count, n_count;
    logic                  w_push;
    logic                  w_pop;

    assign o_full  = (r_count == JOB_CNT_W'(JOB_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + JOB_PTR_W'(1) : r_wr_ptr;
        n_rd_ptr = w_pop ? r_rd_ptr + JOB_PTR_W'(1) : r_rd_ptr;
        n_count  = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + JOB_CNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - JOB_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

`default_nettype wire

// ===== sv/jsu_back.sv =====
// jsu_back: expands queued jobs into output words, utf-8 encoding code points
// depends on jsu_pkg and jsu_out_if
`default_nettype none

module jsu_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_q_valid,
    input  wire jsu_pkg::t_job   i_q_job,
    output logic                 o_pop,
    jsu_out_if.source            o_out
);
    import jsu_pkg::*;

    logic        r_valid;
    logic [7:0]  r_byte;
    t_kind       r_kind;
    logic        r_last;
    logic [1:0]  r_idx, n_idx;

    logic        w_take;
    logic [1:0]  w_len;
    logic        w_final;
    logic [7:0]  w_byte;

    function automatic logic [1:0] utf8_len(input logic [CP_W-1:0] cp);
        logic [1:0] l;
        if (cp < CP_W'(32'h80)) begin
            l = 2'd0;
        end else if (cp < CP_W'(32'h800)) begin
            l = 2'd1;
        end else if (cp < CP_W'(32'h10000)) begin
            l = 2'd2;
        end else begin
            l = 2'd3;
        end
        return l;
    endfunction

    function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] cp,
                                             input logic [1:0] len,
                                             input logic [1:0] idx);
        logic [7:0] v;
        logic [1:0] seg;
        seg = len - idx;
        if (idx == 2'd0) begin
            case (len)
                2'd0:    v = {1'b0, cp[6:0]};
                2'd1:    v = {3'b110, cp[10:6]};
                2'd2:    v = {4'b1110, cp[15:12]};
                default: v = {5'b11110, cp[20:18]};
            endcase
        end else begin
            case (seg)
                2'd0:    v = {2'b10, cp[5:0]};
                2'd1:    v = {2'b10, cp[11:6]};
                default: v = {2'b10, cp[17:12]};
            endcase
        end
        return v;
    endfunction

    always_comb begin
        w_len  = 2'd0;
        w_byte = 8'd0;
        if (i_q_job.kind == KIND_DATA) begin
            if (i_q_job.utf) begin
                w_len  = utf8_len(i_q_job.value);
                w_byte = utf8_byte(i_q_job.value, w_len, r_idx);
            end else begin
                w_byte = i_q_job.value[7:0];
            end
        end
    end

    assign w_take  = !r_valid || o_out.ready;
    assign w_final = (r_idx == w_len);
    assign o_pop   = w_take && i_q_valid && w_final;
    assign n_idx   = w_final ? 2'd0 : r_idx + 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
        end else if (w_take) begin
            r_valid <= i_q_valid;
            if (i_q_valid) begin
                r_idx <= n_idx;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && i_q_valid) begin
            r_byte <= w_byte;
            r_kind <= i_q_job.kind;
            r_last <= w_final;
        end
    end

    assign o_out.valid    = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.kind     = r_kind;
    assign o_out.last     = r_last;

endmodule

`default_nettype wire

// ===== sv/json_string_unescape.sv =====
// json_string_unescape: top level, front classifier, job queue, utf-8 back end
// depends on jsu_pkg, jsu_if, jsu_front, jsu_fifo, jsu_back
//
//   channel  dir  handshake             payload
//   i_in     in   valid/ready           in_byte[7:0]
//   o_out    out  valid/ready           out_byte[7:0], kind[1:0], last
//
// one input word per cycle while not stalled; each leaves as 0 to 4 output words
// output runs one word per cycle unless stalled; each utf-8 byte is its own word
// a 4-entry job queue lets the input keep moving, until full, while output stalls
// reset is synchronous and active low; block is idle awaiting a quote
`default_nettype none

module json_string_unescape (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    jsu_in_if.sink      i_in,
    jsu_out_if.source   o_out
);
    import jsu_pkg::*;

    logic  w_push;
    t_job  w_push_job;
    logic  w_q_full;
    logic  w_q_valid;
    t_job  w_q_job;
    logic  w_pop;

    jsu_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (w_q_full),
        .o_push   (w_push),
        .o_job    (w_push_job)
    );

    jsu_fifo u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_job (w_push_job),
        .o_full     (w_q_full),
        .o_valid    (w_q_valid),
        .o_job      (w_q_job),
        .i_pop      (w_pop)
    );

    jsu_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_job   (w_q_job),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule

`default_nettype wire

// ===== sv/jsu_checker.sv =====
// jsu_checker: port-level checks of json_string_unescape, bound to the top level
// depends on jsu_pkg
`default_nettype none

module jsu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [7:0]  i_out_byte,
    input wire logic [1:0]  i_out_kind,
    input wire logic        i_out_last
);
    import jsu_pkg::*;

    // end markers are single words with a zero byte
    a_marker_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_kind != KIND_DATA) |-> (i_out_last && i_out_byte == 8'd0))
        else $error("end marker word not last or byte nonzero");

    // an accepted utf-8 lead byte that is not the last word is followed by a continuation byte
    a_lead_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_kind == KIND_DATA && i_out_byte[7:6] == 2'b11 && !i_out_last
         && i_out_ready)
        |=> i_out_valid && i_out_kind == KIND_DATA && i_out_byte[7:6] == 2'b10)
        else $error("utf-8 lead byte not followed by continuation");

    a_no_valid_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_byte)
         && $stable(i_out_kind) && $stable(i_out_last)))
        else $error("stalled output word changed");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.out_byte),
    .i_out_kind  (o_out.kind),
    .i_out_last  (o_out.last)
);

`default_nettype wire
